FILE: rtl/assert_macros.svh
// Assertion helper macros for the resampler RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LIR_ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define LIR_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

FILE: rtl/lir_pkg.sv
// Shared types and constants for the linear interpolation resampler.
// No dependencies.
`timescale 1ns / 1ps

package lir_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PHASE_W   = FRAC_BITS + 1;
  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 17;
  localparam int PROD_W    = 2 * (SAMPLE_W + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [PHASE_W-1:0]  phase_t;
  typedef logic        [CFG_W-1:0]    step_cfg_t;

  localparam phase_t    STEP_ONE   = phase_t'(1) << FRAC_BITS;
  localparam phase_t    STEP_MIN   = STEP_ONE >> 5;
  localparam step_cfg_t STEP_RESET = step_cfg_t'(30106);

endpackage

FILE: rtl/lir_interp_unit.sv
// Shared interpolation datapath: one registered signed multiply, then the
// weighted sum and the truncation toward zero. Depends on lir_pkg.
`timescale 1ns / 1ps

module lir_interp_unit (
  input  logic                      clk,
  input  logic                      load,
  input  lir_pkg::sample_t          a,
  input  lir_pkg::sample_t          b,
  input  logic [lir_pkg::FRAC_BITS-1:0] phase,
  output lir_pkg::sample_t          y
);
  import lir_pkg::*;

  logic signed [SAMPLE_W:0]   diff;
  logic signed [PROD_W-1:0]   prod_r;
  sample_t                    a_r;
  logic signed [PROD_W-1:0]   sum;
  logic signed [PROD_W-FRAC_BITS-1:0] quo;
  logic signed [PROD_W-FRAC_BITS-1:0] quo_adj;

  assign diff = (SAMPLE_W+1)'(b) - (SAMPLE_W+1)'(a);

  always_ff @(posedge clk) begin
    if (load) begin
      a_r    <= a;
      prod_r <= PROD_W'(diff * $signed({1'b0, phase}));
    end
  end

  // a*ONE + (b-a)*phase, divided by ONE toward zero
  assign sum = ($signed(PROD_W'(a_r)) <<< FRAC_BITS) + prod_r;
  assign quo = sum[PROD_W-1:FRAC_BITS];

  always_comb begin
    quo_adj = quo;
    if (sum[PROD_W-1] && (sum[FRAC_BITS-1:0] != '0)) begin
      quo_adj = quo + 1'b1;
    end
  end

  assign y = quo_adj[SAMPLE_W-1:0];

endmodule

FILE: rtl/linear_interp_resampler_core.sv
// Top level of the linear interpolation resampler: sequencer, phase
// accumulator, step register and output word register.
// Depends on lir_pkg, lir_interp_unit and assert_macros.svh.
`timescale 1ns / 1ps

// Upsamples signed 16-bit mono words by linear interpolation. Each accepted
// input word is taken in S_IDLE, then each of its output words passes
// through S_MUL (multiply) and S_EMIT (sum and advance the phase); S_EMIT
// waits while the output side stalls, and the multiplier in lir_interp_unit
// is shared by all output words. A first word that is not end-marked, after
// reset or after an end-marked word, only loads as the previous word and
// produces no output. in_stall is high while a word is being worked on. The
// step register is read at every phase advance and saturates to [1/32, 1]
// of a source period.
module linear_interp_resampler_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lir_pkg::sample_t    in_sample,
  input  logic                in_end_of_stream,
  output logic                out_valid,
  input  logic                out_stall,
  output lir_pkg::sample_t    out_sample,
  output logic                out_last_of_run,
  input  logic                cfg_wr_en,
  input  lir_pkg::step_cfg_t  cfg_wr_data
);
  import lir_pkg::*;

  `include "assert_macros.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  step_cfg_t  step_r;
  phase_t     phase_r, phase_nxt;
  sample_t    prev_r, prev_nxt;
  sample_t    cur_r, cur_nxt;
  logic       have_prev_r, have_prev_nxt;
  logic       end_r, end_nxt;
  logic       flush_r, flush_nxt;
  logic       out_valid_r, out_valid_nxt;
  sample_t    out_sample_r, out_sample_nxt;
  logic       out_last_r, out_last_nxt;

  phase_t         eff_step;
  logic [PHASE_W:0] phase_adv;
  logic           in_take;
  logic           out_free;
  sample_t        mul_a;
  sample_t        interp_y;

  always_comb begin
    eff_step = phase_t'(step_r);
    if (step_r < CFG_W'(STEP_MIN)) begin
      eff_step = STEP_MIN;
    end else if (step_r > CFG_W'(STEP_ONE)) begin
      eff_step = STEP_ONE;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign mul_a     = flush_r ? cur_r : prev_r;
  assign phase_adv = {1'b0, phase_r} + {1'b0, eff_step};

  lir_interp_unit u_interp (
    .clk   (clk),
    .load  (state_r == S_MUL),
    .a     (mul_a),
    .b     (cur_r),
    .phase (phase_r[FRAC_BITS-1:0]),
    .y     (interp_y)
  );

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    prev_nxt       = prev_r;
    cur_nxt        = cur_r;
    have_prev_nxt  = have_prev_r;
    end_nxt        = end_r;
    flush_nxt      = flush_r;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          cur_nxt = in_sample;
          end_nxt = in_end_of_stream;
          if (have_prev_r) begin
            flush_nxt = 1'b0;
            state_nxt = S_MUL;
          end else if (in_end_of_stream) begin
            flush_nxt = 1'b1;
            state_nxt = S_MUL;
          end else begin
            prev_nxt      = in_sample;
            have_prev_nxt = 1'b1;
          end
        end
      end
      S_MUL: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = interp_y;
          out_last_nxt   = 1'b0;
          if (phase_adv >= (PHASE_W+1)'(STEP_ONE)) begin
            phase_nxt = PHASE_W'(phase_adv - (PHASE_W+1)'(STEP_ONE));
            if (end_r && !flush_r) begin
              // interval done, flush tail as copies of the last word
              flush_nxt = 1'b1;
              state_nxt = S_MUL;
            end else begin
              out_last_nxt = 1'b1;
              state_nxt    = S_IDLE;
              if (end_r) begin
                prev_nxt      = '0;
                phase_nxt     = '0;
                have_prev_nxt = 1'b0;
              end else begin
                prev_nxt      = cur_r;
                have_prev_nxt = 1'b1;
              end
            end
          end else begin
            phase_nxt = PHASE_W'(phase_adv);
            state_nxt = S_MUL;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_RESET;
      phase_r     <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
      end_r       <= 1'b0;
      flush_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      out_valid_r <= out_valid_nxt;
      end_r       <= end_nxt;
      flush_r     <= flush_nxt;
      if (cfg_wr_en) begin
        step_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_last_of_run = out_last_r;

  `LIR_ASSERT_HOLDS(a_mul_to_emit, clk, rst_n,
    (state_r == S_MUL) |=> (state_r == S_EMIT), "multiply not followed by emit")
  `LIR_ASSERT_NEVER(a_phase_range, clk, rst_n,
    (state_r == S_MUL) && (phase_r >= STEP_ONE), "phase out of interval at multiply")
  `LIR_ASSERT_NEVER(a_idle_reset_phase, clk, rst_n,
    (state_r == S_IDLE) && !have_prev_r && (phase_r != '0),
    "phase nonzero without previous word")
  `LIR_ASSERT_HOLDS(a_start_work, clk, rst_n,
    (in_take && (have_prev_r || in_end_of_stream)) |=> (state_r == S_MUL),
    "input word did not start work")

endmodule
